// ===== sv/bbf_pkg.sv =====
// bbf_pkg: shared types and constants of the branch bit fifo
// opcodes, sequencer states, field widths and the marker search helper
// no dependencies
`default_nettype none

package bbf_pkg;

	typedef enum logic [2:0] {
		OP_APPEND = 3'd0,
		OP_POP    = 3'd1,
		OP_SKIP   = 3'd2,
		OP_PEEK   = 3'd3,
		OP_FLUSH  = 3'd4
	} op_t;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_READ  = 8'b0000_0010,
		S_CAP   = 8'b0000_0100,
		S_SHIFT = 8'b0000_1000,
		S_MASK  = 8'b0001_0000,
		S_WR0   = 8'b0010_0000,
		S_WR1   = 8'b0100_0000,
		S_FIN   = 8'b1000_0000
	} state_t;

	localparam int WORD_W  = 32;
	localparam int OFS_W   = 5;
	localparam int FRAME_W = 96;
	localparam int SH_W    = 7;
	localparam int FIELD_W = 6;
	localparam int WIN_MAX = 58;
	localparam int WCNT_W  = 6;
	localparam int WBITS_W = 58;
	localparam int PEND_W  = 13;
	localparam int OUT_W   = 80;

	// index of the highest set bit, 0 when the byte is 0 or 1
	function automatic logic [2:0] top_bit(input logic [7:0] b);
		logic [2:0] n;
		n = 3'd0;
		for (int i = 1; i < 8; i++) begin
			if (b[i]) begin
				n = 3'(i);
			end
		end
		return n;
	endfunction

endpackage

`default_nettype wire

// ===== sv/bbf_ram.sv =====
// bbf_ram: word store of the bit ring, one write and one registered read port
// no package dependencies
`default_nettype none

module bbf_ram #(
	parameter int ADDR_W = 8,
	parameter int DATA_W = 32
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== sv/bbf_shift.sv =====
// bbf_shift: shared logical right shifter over a three-word frame
// depends on bbf_pkg for the frame and shift amount widths
`default_nettype none

module bbf_shift (
	input  wire logic [bbf_pkg::FRAME_W-1:0] din,
	input  wire logic [bbf_pkg::SH_W-1:0]    shamt,
	output logic      [bbf_pkg::FRAME_W-1:0] dout
);

	// used for window extraction, single bit pop and append field and mask placement
	assign dout = din >> shamt;

endmodule

`default_nettype wire

// ===== sv/branch_bit_fifo_with_peek.sv =====
// branch_bit_fifo_with_peek: top level, sequencer and ring pointers
// depends on bbf_pkg, bbf_ram, bbf_shift
`default_nettype none

// Ring of BUF_BITS taken/not-taken bits (BUF_BITS a power of two, at least 128), kept
// msb-first in 32-bit words of a single-port-read ram. One operation is taken per
// transfer on the s_axis side and gives one result on m_axis. The block works on one
// operation at a time: skip, flush, rejected or empty operations go from transfer
// straight to the finish state; pop and peek take three word reads through the one
// read port and one pass of the shared shifter; an append with bits takes three
// reads, two shifter passes for field and mask and two word writes. A finished result
// sits in the output register, and a new operation is taken while it waits. The ram
// needs no clearing: no result depends on a bit that was never appended.
module branch_bit_fifo_with_peek #(
	parameter int BUF_BITS = 8192
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // trace_byte[7:0], skip_count[15:8]
	input  wire logic [2:0]  s_axis_tuser,  // opcode[2:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// bit_value[0], was_empty[1], window_count[7:2], window_bits[65:8],
	// pending_bits[78:66], rejected[79]
	output logic [79:0]      m_axis_tdata
);

	localparam int PW    = $clog2(BUF_BITS);
	localparam int WW    = PW - bbf_pkg::OFS_W;
	localparam int LIMIT = BUF_BITS - 64;

	bbf_pkg::state_t state_q;

	logic [PW-1:0] rp_q, held_q;
	logic [1:0]    rd_cnt_q;
	logic          rd_pend_q;
	logic          m_valid_q;

	logic [2:0]                    op_q;
	logic [WW-1:0]                 word_q;
	logic [bbf_pkg::SH_W-1:0]      amt_q;
	logic [bbf_pkg::WCNT_W-1:0]    cnt_q;
	logic [bbf_pkg::FIELD_W-1:0]   fld_q, fmsk_q;
	logic [bbf_pkg::FRAME_W-1:0]   frame_q;
	logic [63:0]                   dat_q, msk_q;
	logic                          res_bit_q, res_empty_q, res_rej_q;
	logic [bbf_pkg::WCNT_W-1:0]    res_wcnt_q;
	logic [bbf_pkg::WBITS_W-1:0]   res_wbits_q;
	logic [bbf_pkg::OUT_W-1:0]     m_data_q;

	// input fields
	logic       in_fire;
	logic [2:0] in_op;
	logic [7:0] in_byte, in_skip;

	assign in_op   = s_axis_tuser;
	assign in_byte = s_axis_tdata[7:0];
	assign in_skip = s_axis_tdata[15:8];
	assign s_axis_tready = (state_q == bbf_pkg::S_IDLE);
	assign in_fire = s_axis_tvalid && s_axis_tready;

	// operation decode at transfer
	logic [2:0]                  nb;
	logic [bbf_pkg::FIELD_W-1:0] fld_d, fmsk_d;
	logic [PW:0]                 sum_d;
	logic                        over_d;
	logic [PW-1:0]               base_d, skip_n, held_d, rp_d;
	logic [PW:0]                 skip_x;
	logic [bbf_pkg::WCNT_W-1:0]  peek_c;
	logic                        dec_rej, dec_empty, dec_read;
	logic [WW-1:0]               dec_word;
	logic [bbf_pkg::SH_W-1:0]    dec_amt;
	logic [bbf_pkg::WCNT_W-1:0]  dec_cnt;

	always_comb begin
		nb     = bbf_pkg::top_bit(in_byte) - 3'd1;
		// payload bits left aligned, stop marker shifted out
		fld_d  = in_byte[6:1] << (3'd6 - nb);
		fmsk_d = 6'h3F << (3'd6 - nb);
		sum_d  = {1'b0, held_q} + (PW+1)'(nb);
		over_d = sum_d > (PW+1)'(LIMIT);
		base_d = rp_q + held_q;
		skip_x = (PW+1)'(in_skip);
		skip_n = (skip_x > {1'b0, held_q}) ? held_q : skip_x[PW-1:0];
		peek_c = (held_q > PW'(bbf_pkg::WIN_MAX)) ? bbf_pkg::WCNT_W'(bbf_pkg::WIN_MAX)
			: held_q[bbf_pkg::WCNT_W-1:0];

		dec_rej   = 1'b0;
		dec_empty = 1'b0;
		dec_read  = 1'b0;
		held_d    = held_q;
		rp_d      = rp_q;
		dec_word  = rp_q[PW-1:bbf_pkg::OFS_W];
		dec_cnt   = 6'd1;
		dec_amt   = bbf_pkg::SH_W'(bbf_pkg::FRAME_W - 1) - {2'b0, rp_q[bbf_pkg::OFS_W-1:0]};
		case (in_op)
			bbf_pkg::OP_APPEND: begin
				if (in_byte < 8'd2 || over_d) begin
					dec_rej = 1'b1;
				end else if (nb != 3'd0) begin
					dec_read = 1'b1;
					dec_word = base_d[PW-1:bbf_pkg::OFS_W];
					dec_amt  = {2'b0, base_d[bbf_pkg::OFS_W-1:0]};
					held_d   = sum_d[PW-1:0];
				end
			end
			bbf_pkg::OP_POP: begin
				if (held_q == '0) begin
					dec_empty = 1'b1;
					rp_d      = '0;
				end else begin
					dec_read = 1'b1;
					held_d   = held_q - PW'(1);
					rp_d     = rp_q + PW'(1);
				end
			end
			bbf_pkg::OP_SKIP: begin
				held_d = held_q - skip_n;
				rp_d   = rp_q + skip_n;
			end
			bbf_pkg::OP_PEEK: begin
				if (held_q == '0) begin
					dec_empty = 1'b1;
					rp_d      = '0;
				end else begin
					dec_read = 1'b1;
					dec_cnt  = peek_c;
					dec_amt  = bbf_pkg::SH_W'(bbf_pkg::FRAME_W)
						- {2'b0, rp_q[bbf_pkg::OFS_W-1:0]} - {1'b0, peek_c};
				end
			end
			bbf_pkg::OP_FLUSH: begin
				held_d = '0;
				rp_d   = '0;
			end
			default: begin
			end
		endcase
	end

	// ram and shared shifter
	logic                        mem_we;
	logic [WW-1:0]               mem_waddr, mem_raddr;
	logic [bbf_pkg::WORD_W-1:0]  mem_wdata, mem_rdata;
	logic [bbf_pkg::FRAME_W-1:0] sh_in, sh_out;
	logic                        is_append, out_free;

	assign is_append = (op_q == bbf_pkg::OP_APPEND);
	assign out_free  = !m_valid_q || m_axis_tready;
	assign mem_raddr = word_q + WW'(rd_cnt_q);
	assign mem_we    = (state_q == bbf_pkg::S_WR0) || (state_q == bbf_pkg::S_WR1);

	always_comb begin
		if (state_q == bbf_pkg::S_WR0) begin
			mem_waddr = word_q;
			mem_wdata = (frame_q[95:64] & ~msk_q[63:32]) | dat_q[63:32];
		end else begin
			mem_waddr = word_q + WW'(1);
			mem_wdata = (frame_q[63:32] & ~msk_q[31:0]) | dat_q[31:0];
		end
	end

	always_comb begin
		if (state_q == bbf_pkg::S_MASK) begin
			sh_in = {fmsk_q, {(bbf_pkg::FRAME_W - bbf_pkg::FIELD_W){1'b0}}};
		end else if (is_append) begin
			sh_in = {fld_q, {(bbf_pkg::FRAME_W - bbf_pkg::FIELD_W){1'b0}}};
		end else begin
			sh_in = frame_q;
		end
	end

	bbf_ram #(
		.ADDR_W(WW),
		.DATA_W(bbf_pkg::WORD_W)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	bbf_shift u_shift (
		.din  (sh_in),
		.shamt(amt_q),
		.dout (sh_out)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= bbf_pkg::S_IDLE;
			rp_q      <= '0;
			held_q    <= '0;
			rd_cnt_q  <= 2'd0;
			rd_pend_q <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			rd_pend_q <= (state_q == bbf_pkg::S_READ);
			if (state_q == bbf_pkg::S_FIN && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				bbf_pkg::S_IDLE: begin
					if (in_fire) begin
						held_q   <= held_d;
						rp_q     <= rp_d;
						rd_cnt_q <= 2'd0;
						state_q  <= dec_read ? bbf_pkg::S_READ : bbf_pkg::S_FIN;
					end
				end
				bbf_pkg::S_READ: begin
					rd_cnt_q <= rd_cnt_q + 2'd1;
					if (rd_cnt_q == 2'd2) begin
						state_q <= bbf_pkg::S_CAP;
					end
				end
				bbf_pkg::S_CAP:   state_q <= bbf_pkg::S_SHIFT;
				bbf_pkg::S_SHIFT: state_q <= is_append ? bbf_pkg::S_MASK : bbf_pkg::S_FIN;
				bbf_pkg::S_MASK:  state_q <= bbf_pkg::S_WR0;
				bbf_pkg::S_WR0:   state_q <= bbf_pkg::S_WR1;
				bbf_pkg::S_WR1:   state_q <= bbf_pkg::S_FIN;
				bbf_pkg::S_FIN: begin
					if (out_free) begin
						state_q <= bbf_pkg::S_IDLE;
					end
				end
				default: state_q <= bbf_pkg::S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q        <= in_op;
			word_q      <= dec_word;
			amt_q       <= dec_amt;
			cnt_q       <= dec_cnt;
			fld_q       <= fld_d;
			fmsk_q      <= fmsk_d;
			res_rej_q   <= dec_rej;
			res_empty_q <= dec_empty;
			res_bit_q   <= 1'b0;
			res_wcnt_q  <= '0;
			res_wbits_q <= '0;
		end
		// frame fills msb word first as read data returns
		if (rd_pend_q) begin
			frame_q <= {frame_q[63:0], mem_rdata};
		end
		if (state_q == bbf_pkg::S_SHIFT) begin
			if (is_append) begin
				dat_q <= sh_out[95:32];
			end else if (op_q == bbf_pkg::OP_POP) begin
				res_bit_q <= sh_out[0];
			end else begin
				res_wcnt_q  <= cnt_q;
				res_wbits_q <= sh_out[bbf_pkg::WBITS_W-1:0]
					& ~({bbf_pkg::WBITS_W{1'b1}} << cnt_q);
			end
		end
		if (state_q == bbf_pkg::S_MASK) begin
			msk_q <= sh_out[95:32];
		end
		if (state_q == bbf_pkg::S_FIN && out_free) begin
			m_data_q <= {res_rej_q, bbf_pkg::PEND_W'(held_q), res_wbits_q, res_wcnt_q,
				res_empty_q, res_bit_q};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	a_held_limit: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, held_q} <= (PW+1)'(LIMIT))
		else $error("pending count beyond ring limit");

	a_write_append: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> op_q == bbf_pkg::OP_APPEND)
		else $error("ram write outside an append");

	a_reject_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && in_op == bbf_pkg::OP_APPEND && in_byte < 8'd2
		|=> held_q == $past(held_q) && rp_q == $past(rp_q))
		else $error("rejected append changed the ring");

	a_empty_window: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[7:2] == 6'd0)
		else $error("empty result with a window");

	a_read_seq: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bbf_pkg::S_READ
		|=> state_q == bbf_pkg::S_READ || state_q == bbf_pkg::S_CAP)
		else $error("word read sequence broken");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for branch_bit_fifo_with_peek
// drives op transfers on s_axis, checks m_axis results vs typed rows or a ring predictor
// depends on bbf_pkg and the branch_bit_fifo_with_peek rtl

module tb_top;

	localparam int RING_BITS = 8192;
	localparam int RANDOM_OPS = 725;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 12;

	// opcodes the block leaves without effect
	localparam logic [2:0] OP_RSV5 = 3'd5;
	localparam logic [2:0] OP_RSV6 = 3'd6;
	localparam logic [2:0] OP_RSV7 = 3'd7;

	typedef struct packed {
		logic        rejected;
		logic [12:0] pending_bits;
		logic [57:0] window_bits;
		logic [5:0]  window_count;
		logic        was_empty;
		logic        bit_value;
	} fifo_reply_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  trace_byte;
		logic [7:0]  skip_count;
		logic        typed;
		fifo_reply_t want;
	} drill_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic [2:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [79:0] m_axis_tdata;

	// predictor state: one entry per ring bit
	bit ring_bits [RING_BITS];
	int read_pos = 0;
	int held_bits = 0;

	fifo_reply_t reply_q [$];
	int  fails = 0;
	int  quiet_cycles = 0;
	bit  calm = 1'b0;

	branch_bit_fifo_with_peek dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #10 clk = ~clk;

	function automatic fifo_reply_t reply(input logic bitv, input logic empty,
			input logic [5:0] wcnt, input logic [57:0] wbits, input logic [12:0] pend,
			input logic rej);
		fifo_reply_t r;
		r.bit_value = bitv;
		r.was_empty = empty;
		r.window_count = wcnt;
		r.window_bits = wbits;
		r.pending_bits = pend;
		r.rejected = rej;
		return r;
	endfunction

	// applies one operation to the ring copy and returns the result it must give
	function automatic fifo_reply_t bitfifo_predict(input logic [2:0] op,
			input logic [7:0] tb, input logic [7:0] sk);
		fifo_reply_t r;
		int marker;
		int n;
		r = '0;
		case (op)
			bbf_pkg::OP_APPEND: begin
				marker = 0;
				for (int i = 1; i < 8; i++) begin
					if (tb[i]) begin
						marker = i;
					end
				end
				n = marker - 1;
				if (marker == 0 || held_bits + n > RING_BITS - 64) begin
					r.rejected = 1'b1;
				end else begin
					// bits under the marker, bit 0 dropped, msb first
					for (int i = 0; i < n; i++) begin
						ring_bits[(read_pos + held_bits + i) % RING_BITS] = tb[n - i];
					end
					held_bits += n;
				end
			end
			bbf_pkg::OP_POP: begin
				if (held_bits != 0) begin
					r.bit_value = ring_bits[read_pos];
					held_bits--;
					read_pos = (read_pos + 1) % RING_BITS;
				end else begin
					r.was_empty = 1'b1;
					read_pos = 0;
				end
			end
			bbf_pkg::OP_SKIP: begin
				n = (int'(sk) > held_bits) ? held_bits : int'(sk);
				held_bits -= n;
				read_pos = (read_pos + n) % RING_BITS;
			end
			bbf_pkg::OP_PEEK: begin
				if (held_bits == 0) begin
					r.was_empty = 1'b1;
					read_pos = 0;
				end else begin
					n = (held_bits > bbf_pkg::WIN_MAX) ? bbf_pkg::WIN_MAX : held_bits;
					for (int i = 0; i < n; i++) begin
						r.window_bits = {r.window_bits[56:0],
							ring_bits[(read_pos + i) % RING_BITS]};
					end
					r.window_count = 6'(n);
				end
			end
			bbf_pkg::OP_FLUSH: begin
				held_bits = 0;
				read_pos = 0;
			end
			default: begin
			end
		endcase
		r.pending_bits = 13'(held_bits);
		return r;
	endfunction

	// one op transfer, with random idle cycles in front of it
	task automatic send_op(input logic [2:0] op, input logic [7:0] tb, input logic [7:0] sk,
			input logic typed, input fifo_reply_t want);
		int gap;
		fifo_reply_t model;
		gap = 0;
		while (!calm && $urandom_range(0, 99) < 24) begin
			gap++;
		end
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {sk, tb};
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		model = bitfifo_predict(op, tb, sk);
		reply_q.push_back(typed ? want : model);
	endtask

	// result side: random stalls and field-by-field compare
	always @(posedge clk or negedge arst_n) begin
		fifo_reply_t want;
		fifo_reply_t got;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= calm || ($urandom_range(0, 99) >= 24);
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (reply_q.size() == 0) begin
					$error("result transfer with no expectation waiting: %h", got);
					fails++;
				end else begin
					want = reply_q.pop_front();
					if (got.bit_value !== want.bit_value) begin
						$error("bit_value expected %0d got %0d", want.bit_value, got.bit_value);
						fails++;
					end
					if (got.was_empty !== want.was_empty) begin
						$error("was_empty expected %0d got %0d", want.was_empty, got.was_empty);
						fails++;
					end
					if (got.window_count !== want.window_count) begin
						$error("window_count expected %0d got %0d", want.window_count,
							got.window_count);
						fails++;
					end
					if (got.window_bits !== want.window_bits) begin
						$error("window_bits expected %h got %h", want.window_bits,
							got.window_bits);
						fails++;
					end
					if (got.pending_bits !== want.pending_bits) begin
						$error("pending_bits expected %0d got %0d", want.pending_bits,
							got.pending_bits);
						fails++;
					end
					if (got.rejected !== want.rejected) begin
						$error("rejected expected %0d got %0d", want.rejected, got.rejected);
						fails++;
					end
				end
			end
		end
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		drill_row_t drill [$];
		int r;
		logic [2:0] op;
		logic [7:0] tb;
		logic [7:0] sk;

		// typed rows hold results that follow directly from the op sequence
		drill = '{
			'{bbf_pkg::OP_POP, 8'h00, 8'h00, 1'b1,
				reply(1'b0, 1'b1, 6'd0, 58'd0, 13'd0, 1'b0)},
			'{bbf_pkg::OP_PEEK, 8'h00, 8'h00, 1'b1,
				reply(1'b0, 1'b1, 6'd0, 58'd0, 13'd0, 1'b0)},
			'{bbf_pkg::OP_SKIP, 8'h00, 8'hFF, 1'b1,
				reply(1'b0, 1'b0, 6'd0, 58'd0, 13'd0, 1'b0)},
			'{bbf_pkg::OP_APPEND, 8'h00, 8'h00, 1'b1,
				reply(1'b0, 1'b0, 6'd0, 58'd0, 13'd0, 1'b1)},
			'{bbf_pkg::OP_APPEND, 8'h01, 8'h00, 1'b1,
				reply(1'b0, 1'b0, 6'd0, 58'd0, 13'd0, 1'b1)},
			'{bbf_pkg::OP_APPEND, 8'h02, 8'h00, 1'b1,
				reply(1'b0, 1'b0, 6'd0, 58'd0, 13'd0, 1'b0)},
			'{bbf_pkg::OP_APPEND, 8'h03, 8'h00, 1'b1,
				reply(1'b0, 1'b0, 6'd0, 58'd0, 13'd0, 1'b0)},
			'{bbf_pkg::OP_APPEND, 8'hFF, 8'h00, 1'b1,
				reply(1'b0, 1'b0, 6'd0, 58'd0, 13'd6, 1'b0)},
			'{bbf_pkg::OP_PEEK, 8'h00, 8'h00, 1'b1,
				reply(1'b0, 1'b0, 6'd6, 58'h3F, 13'd6, 1'b0)},
			'{bbf_pkg::OP_APPEND, 8'h80, 8'h00, 1'b1,
				reply(1'b0, 1'b0, 6'd0, 58'd0, 13'd12, 1'b0)},
			'{bbf_pkg::OP_PEEK, 8'h00, 8'h00, 1'b1,
				reply(1'b0, 1'b0, 6'd12, 58'hFC0, 13'd12, 1'b0)},
			'{bbf_pkg::OP_POP, 8'h00, 8'h00, 1'b1,
				reply(1'b1, 1'b0, 6'd0, 58'd0, 13'd11, 1'b0)},
			'{bbf_pkg::OP_SKIP, 8'h00, 8'h05, 1'b1,
				reply(1'b0, 1'b0, 6'd0, 58'd0, 13'd6, 1'b0)},
			'{bbf_pkg::OP_POP, 8'h00, 8'h00, 1'b1,
				reply(1'b0, 1'b0, 6'd0, 58'd0, 13'd5, 1'b0)},
			'{bbf_pkg::OP_SKIP, 8'h00, 8'hFF, 1'b1,
				reply(1'b0, 1'b0, 6'd0, 58'd0, 13'd0, 1'b0)},
			'{bbf_pkg::OP_APPEND, 8'hAB, 8'h00, 1'b0, '0},
			'{bbf_pkg::OP_APPEND, 8'h55, 8'h00, 1'b0, '0},
			'{bbf_pkg::OP_SKIP,   8'h00, 8'h00, 1'b0, '0},
			'{bbf_pkg::OP_PEEK,   8'h00, 8'h00, 1'b0, '0},
			'{OP_RSV5,            8'hFF, 8'hFF, 1'b0, '0},
			'{OP_RSV6,            8'h80, 8'h01, 1'b0, '0},
			'{OP_RSV7,            8'h7F, 8'h80, 1'b0, '0},
			'{bbf_pkg::OP_SKIP,   8'h00, 8'h03, 1'b0, '0},
			'{bbf_pkg::OP_FLUSH, 8'h00, 8'h00, 1'b1,
				reply(1'b0, 1'b0, 6'd0, 58'd0, 13'd0, 1'b0)},
			'{bbf_pkg::OP_POP, 8'h00, 8'h00, 1'b1,
				reply(1'b0, 1'b1, 6'd0, 58'd0, 13'd0, 1'b0)}
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (drill[i]) begin
			send_op(drill[i].op, drill[i].trace_byte, drill[i].skip_count, drill[i].typed,
				drill[i].want);
		end

		for (int n = 0; n < RANDOM_OPS; n++) begin
			calm = (n >= 250 && n < 400);
			r = $urandom_range(0, 99);
			tb = 8'($urandom);
			sk = 8'($urandom);
			if (r < 3) begin
				op = bbf_pkg::OP_APPEND;
				tb = 8'($urandom_range(0, 1));
			end else if (r < 46) begin
				op = bbf_pkg::OP_APPEND;
				tb = 8'($urandom_range(2, 255));
			end else if (r < 61) begin
				op = bbf_pkg::OP_POP;
			end else if (r < 76) begin
				op = bbf_pkg::OP_PEEK;
			end else if (r < 92) begin
				op = bbf_pkg::OP_SKIP;
				if ($urandom_range(0, 9) != 0) begin
					sk = 8'($urandom_range(0, 7));
				end
			end else if (r < 94) begin
				op = bbf_pkg::OP_FLUSH;
			end else if (r < 97) begin
				op = 3'($urandom_range(OP_RSV5, OP_RSV7));
			end else begin
				op = bbf_pkg::OP_APPEND;
			end
			send_op(op, tb, sk, 1'b0, '0);
		end
		calm = 1'b0;
		s_axis_tvalid <= 1'b0;

		while (reply_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fails == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
